>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matmul assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matmul assertion failed");

`endif

>>> rtl/mmg_pkg.sv
// ----------------------------------------------------------------------------
// mmg_pkg
// Shared types, codes and constants of the matrix product engine.
// ----------------------------------------------------------------------------
package mmg_pkg;

  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned OP_W      = 4;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DIM_CFG_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned NUM_STORES = 6;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 4'd0,
    OP_LOAD_B  = 4'd1,
    OP_LOAD_G  = 4'd2,
    OP_LOAD_GA = 4'd3,
    OP_LOAD_GB = 4'd4,
    OP_FWD     = 4'd5,
    OP_BWD     = 4'd6,
    OP_READ_P  = 4'd7,
    OP_READ_GA = 4'd8,
    OP_READ_GB = 4'd9
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_A  = 3'd0,
    ST_B  = 3'd1,
    ST_G  = 3'd2,
    ST_P  = 3'd3,
    ST_GA = 3'd4,
    ST_GB = 3'd5
  } store_e;

  typedef struct packed {
    logic   wr_en;
    store_e wr_sel;
    logic   wr_acc;
    store_e x_sel;
    store_e y_sel;
    logic   mul_en;
    logic   scale;
    logic   acc_clr;
    logic   acc_add;
    logic   out_load;
    logic   out_from_x;
    logic   out_status;
  } dp_cmd_t;

endpackage

>>> rtl/mmg_ifs.sv
// ----------------------------------------------------------------------------
// mmg channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface mmg_in_if import mmg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic [VAL_W-1:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface mmg_out_if import mmg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;
  logic             status;

  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface

interface mmg_cfg_if import mmg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/mmg_ctrl.sv
// ----------------------------------------------------------------------------
// mmg_ctrl
// Sequencer: item decode, range checks, size registers and the loop walk of
// the forward and backward passes over the shared multiply-accumulate.
// ----------------------------------------------------------------------------
module mmg_ctrl import mmg_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF,
  parameter int unsigned IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int unsigned ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [POS_W-1:0]     row_i,
  input  logic [POS_W-1:0]     col_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_CFG_W-1:0] cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dp_cmd_t              cmd_o,
  output logic [ADDR_W-1:0]    wr_addr_o,
  output logic [ADDR_W-1:0]    x_addr_o,
  output logic [ADDR_W-1:0]    y_addr_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_ISSUE, S_MUL, S_ACC, S_WRITE
  } state_e;

  typedef enum logic [1:0] {
    PH_FWD, PH_GA, PH_GB
  } phase_e;

  state_e               state_q;
  phase_e               phase_q;
  logic [IDX_W-1:0]     c0_q, c1_q, c2_q;
  logic                 init_q;
  logic                 out_valid_q;
  logic [DIM_CFG_W-1:0] rows_q, inner_q, cols_q;

  logic [CNT_W-1:0]  nr, nk, nc, n0, n1, n2, lim_r, lim_c;
  logic [IDX_W-1:0]  ii, jj, kk;
  logic              last0, last1, last2, range_err, out_free, accept;
  logic [ADDR_W-1:0] in_addr, dest_addr;
  store_e            in_sel, dest_sel;

  function automatic logic [CNT_W-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  assign nr = eff_dim(rows_q);
  assign nk = eff_dim(inner_q);
  assign nc = eff_dim(cols_q);

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lim_r  = nr;
    lim_c  = nk;
    in_sel = ST_A;
    case (op_e'(op_i))
      OP_LOAD_A:  begin lim_r = nr; lim_c = nk; in_sel = ST_A;  end
      OP_LOAD_B:  begin lim_r = nk; lim_c = nc; in_sel = ST_B;  end
      OP_LOAD_G:  begin lim_r = nr; lim_c = nc; in_sel = ST_G;  end
      OP_LOAD_GA: begin lim_r = nr; lim_c = nk; in_sel = ST_GA; end
      OP_LOAD_GB: begin lim_r = nk; lim_c = nc; in_sel = ST_GB; end
      OP_READ_P:  begin lim_r = nr; lim_c = nc; in_sel = ST_P;  end
      OP_READ_GA: begin lim_r = nr; lim_c = nk; in_sel = ST_GA; end
      OP_READ_GB: begin lim_r = nk; lim_c = nc; in_sel = ST_GB; end
      default:    begin lim_r = nr; lim_c = nk; in_sel = ST_A;  end
    endcase
  end

  assign range_err = (CMP_W'(row_i) >= CMP_W'(lim_r)) || (CMP_W'(col_i) >= CMP_W'(lim_c));
  assign in_addr   = cell_addr(IDX_W'(row_i), IDX_W'(col_i));

  always_comb begin
    case (phase_q)
      PH_GA: begin
        n0 = nr; n1 = nk; n2 = nc;
        ii = c0_q; kk = c1_q; jj = c2_q;
        dest_sel = ST_GA;
      end
      PH_GB: begin
        n0 = nk; n1 = nc; n2 = nr;
        kk = c0_q; jj = c1_q; ii = c2_q;
        dest_sel = ST_GB;
      end
      default: begin
        n0 = nr; n1 = nc; n2 = nk;
        ii = c0_q; jj = c1_q; kk = c2_q;
        dest_sel = ST_P;
      end
    endcase
  end

  assign last0     = (CNT_W'(c0_q) == n0 - CNT_W'(1));
  assign last1     = (CNT_W'(c1_q) == n1 - CNT_W'(1));
  assign last2     = (CNT_W'(c2_q) == n2 - CNT_W'(1));
  assign dest_addr = cell_addr(c0_q, c1_q);

  always_comb begin
    cmd_o     = '0;
    cmd_o.wr_sel = ST_A;
    cmd_o.x_sel  = ST_A;
    cmd_o.y_sel  = ST_A;
    wr_addr_o = dest_addr;
    x_addr_o  = in_addr;
    y_addr_o  = in_addr;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_LOAD_A, OP_LOAD_B, OP_LOAD_G, OP_LOAD_GA, OP_LOAD_GB: begin
              cmd_o.wr_en      = !range_err;
              cmd_o.wr_sel     = in_sel;
              wr_addr_o        = in_addr;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = range_err ? STATUS_RANGE : STATUS_OK;
            end
            OP_FWD, OP_BWD: begin
              cmd_o.acc_clr = 1'b1;
            end
            OP_READ_P, OP_READ_GA, OP_READ_GB: begin
              cmd_o.x_sel      = in_sel;
              cmd_o.out_load   = range_err;
              cmd_o.out_status = STATUS_RANGE;
            end
            default: begin
              cmd_o.acc_clr = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_from_x = 1'b1;
        cmd_o.out_status = STATUS_OK;
      end
      S_ISSUE: begin
        if (init_q) begin
          cmd_o.x_sel = dest_sel;
          x_addr_o    = dest_addr;
        end else begin
          case (phase_q)
            PH_GA: begin
              cmd_o.x_sel = ST_G; x_addr_o = cell_addr(ii, jj);
              cmd_o.y_sel = ST_B; y_addr_o = cell_addr(kk, jj);
            end
            PH_GB: begin
              cmd_o.x_sel = ST_A; x_addr_o = cell_addr(ii, kk);
              cmd_o.y_sel = ST_G; y_addr_o = cell_addr(ii, jj);
            end
            default: begin
              cmd_o.x_sel = ST_A; x_addr_o = cell_addr(ii, kk);
              cmd_o.y_sel = ST_B; y_addr_o = cell_addr(kk, jj);
            end
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.scale  = init_q;
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
      end
      S_WRITE: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_acc     = 1'b1;
        cmd_o.wr_sel     = dest_sel;
        cmd_o.acc_clr    = 1'b1;
        cmd_o.out_load   = last0 && last1 && (phase_q != PH_GA);
        cmd_o.out_status = STATUS_OK;
      end
      default: begin
        cmd_o.acc_clr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FWD;
      c0_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rows_q      <= DIM_CFG_W'(MAX_DIM_DEF);
      inner_q     <= DIM_CFG_W'(MAX_DIM_DEF);
      cols_q      <= DIM_CFG_W'(MAX_DIM_DEF);
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ROWS:  rows_q  <= cfg_data_i;
          CFG_INNER: inner_q <= cfg_data_i;
          CFG_COLS:  cols_q  <= cfg_data_i;
          default:   rows_q  <= rows_q;
        endcase
      end

      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_e'(op_i))
              OP_FWD, OP_BWD: begin
                state_q <= S_ISSUE;
                phase_q <= (op_e'(op_i) == OP_FWD) ? PH_FWD : PH_GA;
                init_q  <= (op_e'(op_i) == OP_BWD);
                c0_q    <= '0;
                c1_q    <= '0;
                c2_q    <= '0;
              end
              OP_READ_P, OP_READ_GA, OP_READ_GB: begin
                if (!range_err) begin
                  state_q <= S_READ;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ:  state_q <= S_IDLE;
        S_ISSUE: state_q <= S_MUL;
        S_MUL:   state_q <= S_ACC;
        S_ACC: begin
          if (init_q) begin
            init_q  <= 1'b0;
            state_q <= S_ISSUE;
          end else if (last2) begin
            state_q <= S_WRITE;
          end else begin
            c2_q    <= c2_q + IDX_W'(1);
            state_q <= S_ISSUE;
          end
        end
        S_WRITE: begin
          c2_q    <= '0;
          init_q  <= (phase_q != PH_FWD);
          state_q <= S_ISSUE;
          if (last1) begin
            c1_q <= '0;
            if (last0) begin
              c0_q <= '0;
              if (phase_q == PH_GA) begin
                phase_q <= PH_GB;
              end else begin
                state_q <= S_IDLE;
              end
            end else begin
              c0_q <= c0_q + IDX_W'(1);
            end
          end else begin
            c1_q <= c1_q + IDX_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/mmg_dpath.sv
// ----------------------------------------------------------------------------
// mmg_dpath
// Element stores, the multiply-accumulate unit, the fraction shift with saturation and
// the result register.
// ----------------------------------------------------------------------------
module mmg_dpath import mmg_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [ADDR_W-1:0] x_addr_i,
  input  logic [ADDR_W-1:0] y_addr_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic [VAL_W-1:0]  data_o,
  output logic              status_o
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_DIM + 1);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

  logic [VAL_W-1:0]  rd_data [NUM_STORES];
  logic [ADDR_W-1:0] raddr   [NUM_STORES];
  logic [VAL_W-1:0]  wr_data;

  logic [DEPTH-1:0] ga_vld_q, gb_vld_q;
  logic             ga_rv_q, gb_rv_q;
  store_e           x_sel_q, y_sel_q;

  logic signed [VAL_W-1:0]  xs, ys;
  logic signed [PROD_W-1:0] prod_q, mul_res, scaled;
  logic signed [ACC_W-1:0]  acc_q, shifted;
  logic [VAL_W-1:0]         sat_val;
  logic [VAL_W-1:0]         data_q;
  logic                     status_q;

  for (genvar s = 0; s < NUM_STORES; s++) begin : g_store
    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_q;

    assign raddr[s]   = (cmd_i.x_sel == store_e'(s)) ? x_addr_i : y_addr_i;
    assign rd_data[s] = rd_q;

    always_ff @(posedge clk_i) begin
      if (cmd_i.wr_en && (cmd_i.wr_sel == store_e'(s))) begin
        mem[wr_addr_i] <= wr_data;
      end
      rd_q <= mem[raddr[s]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_vld_q <= '0;
      gb_vld_q <= '0;
      ga_rv_q  <= 1'b0;
      gb_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_en && (cmd_i.wr_sel == ST_GA)) begin
        ga_vld_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.wr_en && (cmd_i.wr_sel == ST_GB)) begin
        gb_vld_q[wr_addr_i] <= 1'b1;
      end
      ga_rv_q <= ga_vld_q[raddr[ST_GA]];
      gb_rv_q <= gb_vld_q[raddr[ST_GB]];
    end
  end

  function automatic logic [VAL_W-1:0] pick(input store_e sel,
                                            input logic [VAL_W-1:0] d [NUM_STORES],
                                            input logic ga_ok, input logic gb_ok);
    logic [VAL_W-1:0] r;
    case (sel)
      ST_A:    r = d[ST_A];
      ST_B:    r = d[ST_B];
      ST_G:    r = d[ST_G];
      ST_P:    r = d[ST_P];
      ST_GA:   r = ga_ok ? d[ST_GA] : '0;
      ST_GB:   r = gb_ok ? d[ST_GB] : '0;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign xs = pick(x_sel_q, rd_data, ga_rv_q, gb_rv_q);
  assign ys = pick(y_sel_q, rd_data, ga_rv_q, gb_rv_q);

  assign mul_res = xs * ys;
  assign scaled  = PROD_W'(xs) <<< FRAC_BITS;

  assign shifted = acc_q >>> FRAC_BITS;
  always_comb begin
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[VAL_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[VAL_W-1:0];
    end else begin
      sat_val = shifted[VAL_W-1:0];
    end
  end

  assign wr_data = cmd_i.wr_acc ? sat_val : value_i;

  always_ff @(posedge clk_i) begin
    x_sel_q <= cmd_i.x_sel;
    y_sel_q <= cmd_i.y_sel;
    if (cmd_i.mul_en) begin
      prod_q <= cmd_i.scale ? scaled : mul_res;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.out_load) begin
      data_q   <= cmd_i.out_from_x ? xs : '0;
      status_q <= cmd_i.out_status;
    end
  end

  assign data_o   = data_q;
  assign status_o = status_q;

endmodule

>>> rtl/matmul_with_gradients.sv
// ----------------------------------------------------------------------------
// matmul_with_gradients
// Loads give their result in the cycle after acceptance and run one per cycle
// while the engine is idle and its result is taken; reads of P, gA or gB pass
// through the registered store read port, then S_READ and the result register.
// A forward or backward pass steps through store read, multiply and add for each
// multiply-accumulate, which is the only arithmetic unit.
// Reset sets all sizes to 8 and makes gA and gB read zero through per-entry
// valid flags, so items are accepted right after reset.
// ----------------------------------------------------------------------------
module matmul_with_gradients import mmg_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmg_in_if.sink    in_i,
  mmg_out_if.source out_o,
  mmg_cfg_if.sink   cfg_i
);

  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  dp_cmd_t           cmd;
  logic [ADDR_W-1:0] wr_addr, x_addr, y_addr;

  mmg_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .op_i        (in_i.op),
    .row_i       (in_i.row),
    .col_i       (in_i.col),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .x_addr_o    (x_addr),
    .y_addr_o    (y_addr)
  );

  mmg_dpath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .ADDR_W    (ADDR_W)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (wr_addr),
    .x_addr_i  (x_addr),
    .y_addr_i  (y_addr),
    .value_i   (in_i.value),
    .data_o    (out_o.data),
    .status_o  (out_o.status)
  );

endmodule

>>> rtl/mmg_checker.sv
// ----------------------------------------------------------------------------
// mmg_checker
// Port-level checks of the matrix product engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmg_checker import mmg_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [OP_W-1:0]  in_op_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VAL_W-1:0] out_data_i,
  input logic             out_status_i
);

  logic in_xact;

  assign in_xact = in_valid_i && in_ready_i;

  `MMG_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `MMG_ASSERT_NOW(a_err_zero, out_valid_i && (out_status_i == STATUS_RANGE), out_data_i == '0)
  `MMG_ASSERT_NOW(a_backpressure, out_valid_i && !out_ready_i, !in_ready_i)
  `MMG_ASSERT_NEXT(a_load_resp, in_xact && (in_op_i <= OP_LOAD_GB), out_valid_i)
  `MMG_ASSERT_NEXT(a_unused_quiet, in_xact && (in_op_i > OP_READ_GB), !out_valid_i)

endmodule

bind matmul_with_gradients mmg_checker u_mmg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data),
  .out_status_i (out_o.status)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the matrix product engine. A short table of
// directed transactions is followed by random phases under several size
// settings. Results are checked against the table's expected values or against
// a predictor that keeps its own copy of all six stores and of the sizes.
// ----------------------------------------------------------------------------
module testbench;
  import mmg_pkg::*;

  localparam int unsigned DIM = MAX_DIM_DEF;
  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned CELLS = DIM * DIM;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd10;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST = 4'd15;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned NUM_PHASES = 7;

  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic             status;
  } result_t;

  typedef struct packed {
    bit               is_cfg;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [VAL_W-1:0] value;
    bit               typed;
    logic [VAL_W-1:0] exp_data;
    logic             exp_status;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mmg_in_if  in_ch ();
  mmg_out_if out_ch ();
  mmg_cfg_if cfg_ch ();

  matmul_with_gradients i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  int   mat_a [CELLS];
  int   mat_b [CELLS];
  int   out_grad [CELLS];
  int   product [CELLS];
  int   grad_a [CELLS];
  int   grad_b [CELLS];
  bit   a_set [CELLS];
  bit   b_set [CELLS];
  bit   g_set [CELLS];
  bit   p_set [CELLS];
  logic [DIM_CFG_W-1:0] dims [3];

  result_t pending_results [$];
  int      fail_count = 0;
  bit      tx_calm = 1'b1;
  bit      rx_calm = 1'b1;
  int      rx_stall = 0;

  // Sizes are {cols, inner, rows} in the low bits of value for size rows.
  step_t directed [25] = '{
    '{1'b0, OP_READ_GA, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_GB, 3'd7, 3'd7, 32'h0, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_LOAD_GA, 3'd7, 3'd7, 32'h7fffffff, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_GA, 3'd7, 3'd7, 32'h0, 1'b1, 32'h7fffffff, STATUS_OK},
    '{1'b0, OP_LOAD_GB, 3'd0, 3'd0, 32'h80000000, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_GB, 3'd0, 3'd0, 32'h0, 1'b1, 32'h80000000, STATUS_OK},
    '{1'b0, OP_UNUSED_FIRST, 3'd1, 3'd2, 32'hffffffff, 1'b0, 32'h0, STATUS_OK},
    '{1'b0, OP_UNUSED_LAST, 3'd7, 3'd7, 32'h12345678, 1'b0, 32'h0, STATUS_OK},
    '{1'b1, OP_LOAD_A, 3'd0, 3'd0, 32'h111, 1'b0, 32'h0, STATUS_OK},
    '{1'b0, OP_LOAD_A, 3'd0, 3'd0, 32'h7fffffff, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_LOAD_B, 3'd0, 3'd0, 32'h7fffffff, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_FWD, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_P, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7fffffff, STATUS_OK},
    '{1'b0, OP_LOAD_A, 3'd0, 3'd1, 32'h1, 1'b1, 32'h0, STATUS_RANGE},
    '{1'b0, OP_READ_P, 3'd1, 3'd0, 32'h0, 1'b1, 32'h0, STATUS_RANGE},
    '{1'b0, OP_LOAD_B, 3'd0, 3'd0, 32'h80000000, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_FWD, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_P, 3'd0, 3'd0, 32'h0, 1'b1, 32'h80000000, STATUS_OK},
    '{1'b0, OP_LOAD_G, 3'd0, 3'd0, 32'h00010000, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_BWD, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_GA, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_GB, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, STATUS_OK},
    '{1'b1, OP_LOAD_A, 3'd0, 3'd0, 32'h000, 1'b0, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_P, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, STATUS_OK},
    '{1'b0, OP_READ_P, 3'd0, 3'd1, 32'h0, 1'b1, 32'h0, STATUS_RANGE}
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #(100_000_000);
    $display("** matmul_with_gradients: FAILED **");
    $finish;
  end

  function automatic int unsigned eff_size(input logic [DIM_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return 32'(v);
  endfunction

  function automatic int saturate(input logic signed [79:0] sum);
    logic signed [79:0] s;
    s = sum >>> FRAC;
    if (s > 80'sd2147483647) return 32'h7fffffff;
    if (s < -80'sd2147483648) return 32'h80000000;
    return int'(s[31:0]);
  endfunction

  task automatic bounds(input logic [OP_W-1:0] op, output int unsigned lr, lc);
    int unsigned nr, nk, nc;
    nr = eff_size(dims[0]);
    nk = eff_size(dims[1]);
    nc = eff_size(dims[2]);
    case (op)
      OP_LOAD_A, OP_LOAD_GA, OP_READ_GA: begin lr = nr; lc = nk; end
      OP_LOAD_B, OP_LOAD_GB, OP_READ_GB: begin lr = nk; lc = nc; end
      default: begin lr = nr; lc = nc; end
    endcase
  endtask

  task automatic run_forward();
    int unsigned nr, nk, nc;
    logic signed [79:0] sum;
    nr = eff_size(dims[0]);
    nk = eff_size(dims[1]);
    nc = eff_size(dims[2]);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        sum = '0;
        for (int k = 0; k < nk; k++)
          sum += 80'(longint'(mat_a[i*DIM+k]) * longint'(mat_b[k*DIM+j]));
        product[i*DIM+j] = saturate(sum);
        p_set[i*DIM+j] = 1'b1;
      end
    end
  endtask

  task automatic run_backward();
    int unsigned nr, nk, nc;
    logic signed [79:0] sum;
    nr = eff_size(dims[0]);
    nk = eff_size(dims[1]);
    nc = eff_size(dims[2]);
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nk; k++) begin
        sum = 80'(longint'(grad_a[i*DIM+k])) <<< FRAC;
        for (int j = 0; j < nc; j++)
          sum += 80'(longint'(out_grad[i*DIM+j]) * longint'(mat_b[k*DIM+j]));
        grad_a[i*DIM+k] = saturate(sum);
      end
    end
    for (int k = 0; k < nk; k++) begin
      for (int j = 0; j < nc; j++) begin
        sum = 80'(longint'(grad_b[k*DIM+j])) <<< FRAC;
        for (int i = 0; i < nr; i++)
          sum += 80'(longint'(mat_a[i*DIM+k]) * longint'(out_grad[i*DIM+j]));
        grad_b[k*DIM+j] = saturate(sum);
      end
    end
  endtask

  task automatic apply_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] row, col,
                            input logic [VAL_W-1:0] value, output bit has,
                            output result_t res);
    int unsigned lr, lc, addr;
    has = 1'b0;
    res = '{data: '0, status: STATUS_OK};
    if (op > OP_READ_GB) return;
    has = 1'b1;
    if (op == OP_FWD) begin
      run_forward();
      return;
    end
    if (op == OP_BWD) begin
      run_backward();
      return;
    end
    bounds(op, lr, lc);
    if (row >= lr || col >= lc) begin
      res.status = STATUS_RANGE;
      return;
    end
    addr = row * DIM + col;
    case (op)
      OP_LOAD_A: begin mat_a[addr] = value; a_set[addr] = 1'b1; end
      OP_LOAD_B: begin mat_b[addr] = value; b_set[addr] = 1'b1; end
      OP_LOAD_G: begin out_grad[addr] = value; g_set[addr] = 1'b1; end
      OP_LOAD_GA: grad_a[addr] = value;
      OP_LOAD_GB: grad_b[addr] = value;
      OP_READ_P: res.data = product[addr];
      OP_READ_GA: res.data = grad_a[addr];
      default: res.data = grad_b[addr];
    endcase
  endtask

  // Finds an operand entry that a compute transaction would read unwritten.
  function automatic bit find_gap(input bit backward, output logic [OP_W-1:0] op,
                                  output logic [POS_W-1:0] row, col);
    int unsigned nr, nk, nc;
    nr = eff_size(dims[0]);
    nk = eff_size(dims[1]);
    nc = eff_size(dims[2]);
    op = OP_LOAD_A;
    row = '0;
    col = '0;
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_set[i*DIM+k]) begin
          op = OP_LOAD_A; row = POS_W'(i); col = POS_W'(k); return 1'b1;
        end
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_set[k*DIM+j]) begin
          op = OP_LOAD_B; row = POS_W'(k); col = POS_W'(j); return 1'b1;
        end
    if (backward)
      for (int i = 0; i < nr; i++)
        for (int j = 0; j < nc; j++)
          if (!g_set[i*DIM+j]) begin
            op = OP_LOAD_G; row = POS_W'(i); col = POS_W'(j); return 1'b1;
          end
    return 1'b0;
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'hffffffff;
          default: return 32'h0;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    endcase
  endfunction

  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_sizes(input logic [DIM_CFG_W-1:0] r, k, c);
    logic [DIM_CFG_W-1:0] vals [3];
    vals = '{r, k, c};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_ch.index = cfg_idx_e'(i);
      cfg_ch.data = vals[i];
      cfg_ch.valid = 1'b1;
      do @(posedge clk_i); while (!cfg_ch.ready);
      dims[i] = vals[i];
      @(negedge clk_i);
      cfg_ch.valid = 1'b0;
    end
  endtask

  task automatic send(input logic [OP_W-1:0] op, input logic [POS_W-1:0] row, col,
                      input logic [VAL_W-1:0] value, input bit typed, input result_t want);
    int gap;
    bit has;
    result_t res;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.op = op;
    in_ch.row = row;
    in_ch.col = col;
    in_ch.value = value;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_item(op, row, col, value, has, res);
    if (has) pending_results.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      out_ch.ready = 1'b0;
      rx_stall--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: data %h status %b", out_ch.data, out_ch.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data !== want.data) begin
          $error("data: expected %h, actual %h", want.data, out_ch.data);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %b, actual %b", want.status, out_ch.status);
          fail_count++;
        end
      end
      rx_stall = rx_calm ? 0 : $urandom_range(0, 17);
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] row, col;
    logic [VAL_W-1:0] value;
    int unsigned      lr, lc, r, done;
    logic [DIM_CFG_W-1:0] plan [NUM_PHASES][3];

    plan = '{'{4'd2, 4'd3, 4'd4}, '{4'd8, 4'd8, 4'd8}, '{4'd0, 4'd15, 4'd1},
             '{4'd1, 4'd8, 4'd1}, '{4'd15, 4'd15, 4'd15}, '{4'd5, 4'd2, 4'd7},
             '{4'd3, 4'd3, 4'd3}};
    for (int i = 0; i < CELLS; i++) begin
      mat_a[i] = 0; mat_b[i] = 0; out_grad[i] = 0; product[i] = 0;
      grad_a[i] = 0; grad_b[i] = 0;
      a_set[i] = 1'b0; b_set[i] = 1'b0; g_set[i] = 1'b0; p_set[i] = 1'b0;
    end
    dims = '{4'd8, 4'd8, 4'd8};
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD_A;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ROWS;
    cfg_ch.data = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg)
        write_sizes(directed[i].value[3:0], directed[i].value[7:4], directed[i].value[11:8]);
      else
        send(directed[i].op, directed[i].row, directed[i].col, directed[i].value,
             directed[i].typed, '{data: directed[i].exp_data, status: directed[i].exp_status});
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_sizes(plan[ph][0], plan[ph][1], plan[ph][2]);
      tx_calm = (ph == 0) ? 1'b1 : $urandom_range(0, 2) == 0;
      rx_calm = (ph == 0) ? 1'b1 : $urandom_range(0, 2) == 0;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        value = draw_value();
        row = POS_W'($urandom_range(0, 7));
        col = POS_W'($urandom_range(0, 7));
        if (r < 4) begin
          op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end else if (r < 50) begin
          if (!($urandom_range(0, 1) && find_gap($urandom_range(0, 1), op, row, col))) begin
            op = OP_W'($urandom_range(OP_LOAD_A, OP_LOAD_GB));
            bounds(op, lr, lc);
            if ($urandom_range(0, 9) != 0) begin
              row = POS_W'($urandom_range(0, lr - 1));
              col = POS_W'($urandom_range(0, lc - 1));
            end
          end
        end else if (r < 62) begin
          if (!find_gap(r >= 56, op, row, col)) op = (r >= 56) ? OP_BWD : OP_FWD;
        end else begin
          op = OP_W'($urandom_range(OP_READ_P, OP_READ_GB));
          bounds(op, lr, lc);
          if ($urandom_range(0, 9) != 0) begin
            row = POS_W'($urandom_range(0, lr - 1));
            col = POS_W'($urandom_range(0, lc - 1));
          end
          if (op == OP_READ_P && row < lr && col < lc && !p_set[row*DIM+col])
            if (!find_gap(1'b0, op, row, col)) op = OP_FWD;
        end
        send(op, row, col, value, 1'b0, '0);
        if (op <= OP_READ_GB) done++;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("** matmul_with_gradients: PASSED **");
    end else begin
      $display("** matmul_with_gradients: FAILED **");
    end
    $finish;
  end

endmodule
